### src/prit_pkg.sv
// shared constants, types and the divider step for the reprojection inlier test
package prit_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int INDEX_PORT_BITS = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int PROJ_REGS = 6;
    localparam int DIV_BITS = 40;
    localparam int PROJ_STAGES = 2;
    localparam int SIDE_DEPTH = PROJ_STAGES + 1 + DIV_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW0_01 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW0_23 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW1_01 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW1_23 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW2_01 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW2_23 = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;
    localparam logic [47:0] ERR_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] image_u;
        logic signed [31:0] image_v;
        logic               last;
    } t_side;

    typedef struct packed {
        logic [63:0] rem;
        logic [39:0] low;
        logic [39:0] quo;
        logic [63:0] den;
        logic        ovf;
        logic        neg;
    } t_div_st;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    function automatic t_div_st div_step(t_div_st s);
        t_div_st     o;
        logic [64:0] t;
        logic [64:0] d;
        logic        ge;
        o  = s;
        t  = {s.rem, s.low[39]};
        d  = {1'b0, s.den};
        ge = (t >= d);
        o.rem = ge ? 64'(t - d) : t[63:0];
        o.low = {s.low[38:0], 1'b0};
        o.quo = {s.quo[38:0], ge};
        return o;
    endfunction

endpackage

### src/prit_project.sv
// two-stage projection of the world point through the 3x4 matrix
module prit_project (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [5:0][63:0]          i_coef,
    input  logic signed [31:0]        i_world_x,
    input  logic signed [31:0]        i_world_y,
    input  logic signed [31:0]        i_world_z,
    output logic                      o_valid,
    output logic [2:0]                o_neg,
    output logic [2:0][63:0]          o_mag
);

    logic signed [63:0] n_prod [3][3];
    logic signed [31:0] n_off  [3];
    logic signed [63:0] r_prod [3][3];
    logic signed [31:0] r_off  [3];
    logic               r_vld1;
    logic [2:0]         n_neg;
    logic [2:0][63:0]   n_mag;
    logic signed [65:0] sum [3];
    logic signed [31:0] w [3];

    assign w[0] = i_world_x;
    assign w[1] = i_world_y;
    assign w[2] = i_world_z;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r][c] = $signed(i_coef[2*r + c/2][(c%2)*32 +: 32]) * w[c];
            end
            n_off[r] = $signed(i_coef[2*r + 1][63:32]);
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum[r] = 66'(r_prod[r][0]) + 66'(r_prod[r][1]) + 66'(r_prod[r][2])
                   + $signed({{18{r_off[r][31]}}, r_off[r], 16'b0});
            n_neg[r] = sum[r][65];
            n_mag[r] = sum[r][65] ? 64'(-sum[r]) : 64'(sum[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1  <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_vld1  <= i_valid;
            o_valid <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_off  <= n_off;
            o_neg  <= n_neg;
            o_mag  <= n_mag;
        end
    end

endmodule

### src/prit_divider.sv
// pipelined restoring divider, floor(num*2^16/den), one quotient bit per stage
module prit_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    input  logic        i_neg,
    output logic        o_valid,
    output logic [39:0] o_quo,
    output logic        o_ovf,
    output logic        o_neg,
    output logic        o_den_zero
);

    prit_pkg::t_div_st r_st  [0:prit_pkg::DIV_BITS];
    logic              r_vld [0:prit_pkg::DIV_BITS];
    prit_pkg::t_div_st n_init;

    // quotient must stay below 2^40, so the top 40 dividend bits start below den
    always_comb begin
        n_init.rem = {24'b0, i_num[63:24]};
        n_init.low = {i_num[23:0], 16'b0};
        n_init.quo = '0;
        n_init.den = i_den;
        n_init.ovf = ({24'b0, i_num[63:24]} >= i_den);
        n_init.neg = i_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_init;
        end
    end

    for (genvar k = 1; k <= prit_pkg::DIV_BITS; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= prit_pkg::div_step(r_st[k-1]);
            end
        end
    end

    assign o_valid    = r_vld[prit_pkg::DIV_BITS];
    assign o_quo      = r_st[prit_pkg::DIV_BITS].quo;
    assign o_ovf      = r_st[prit_pkg::DIV_BITS].ovf;
    assign o_neg      = r_st[prit_pkg::DIV_BITS].neg;
    assign o_den_zero = (r_st[prit_pkg::DIV_BITS].den == 64'd0);

endmodule

### src/prit_error.sv
// difference, squares, saturating sum and threshold compare, three stages
module prit_error #(
    parameter int IDX_W = prit_pkg::INDEX_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [39:0]        i_quo_u,
    input  logic               i_ovf_u,
    input  logic               i_neg_u,
    input  logic [39:0]        i_quo_v,
    input  logic               i_ovf_v,
    input  logic               i_neg_v,
    input  logic               i_zero,
    input  prit_pkg::t_side    i_side,
    input  logic [IDX_W-1:0]   i_index,
    input  logic [47:0]        i_limit,
    output logic               o_valid,
    output logic [IDX_W-1:0]   o_index,
    output logic               o_inlier,
    output logic [47:0]        o_sq_error,
    output logic               o_zero,
    output logic               o_last
);

    logic               r_vld1, r_vld2;
    logic [31:0]        r_du, r_dv;
    logic               r_bad1, r_bad2;
    logic               r_zero1, r_zero2;
    logic               r_last1, r_last2;
    logic [IDX_W-1:0]   r_idx1, r_idx2;
    logic [63:0]        r_sq_u, r_sq_v;
    logic [31:0]        n_du, n_dv;
    logic               n_bad_u, n_bad_v;
    logic [64:0]        s;
    logic [47:0]        n_err;

    function automatic logic [32:0] diff_mag(logic [39:0] q, logic neg,
                                             logic signed [31:0] obs);
        logic signed [41:0] val;
        logic signed [41:0] d;
        logic [41:0]        m;
        val = neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
        d   = val - 42'(obs);
        m   = d[41] ? 42'(-d) : 42'(d);
        return {(m[41:32] != 10'd0), m[31:0]};
    endfunction

    assign {n_bad_u, n_du} = diff_mag(i_quo_u, i_neg_u, i_side.image_u);
    assign {n_bad_v, n_dv} = diff_mag(i_quo_v, i_neg_v, i_side.image_v);

    always_comb begin
        s = 65'(r_sq_u) + 65'(r_sq_v);
        if (r_bad2 || r_zero2 || (s[64] != 1'b0)) begin
            n_err = prit_pkg::ERR_MAX;
        end else begin
            n_err = s[63:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1  <= 1'b0;
            r_vld2  <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_vld1  <= i_valid;
            r_vld2  <= r_vld1;
            o_valid <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_du       <= n_du;
            r_dv       <= n_dv;
            r_bad1     <= n_bad_u | n_bad_v | i_ovf_u | i_ovf_v;
            r_zero1    <= i_zero;
            r_last1    <= i_side.last;
            r_idx1     <= i_index;
            r_sq_u     <= r_du * r_du;
            r_sq_v     <= r_dv * r_dv;
            r_bad2     <= r_bad1;
            r_zero2    <= r_zero1;
            r_last2    <= r_last1;
            r_idx2     <= r_idx1;
            o_sq_error <= n_err;
            o_inlier   <= (n_err < i_limit);
            o_zero     <= r_zero2;
            o_last     <= r_last2;
            o_index    <= r_idx2;
        end
    end

endmodule

### src/point_reprojection_inlier_test_top.sv
// top level of the pinhole reprojection error and inlier test
//
//  channel   direction  handshake              payload
//  point     in         i_valid / o_stall      world x,y,z, image u,v, index, last
//  result    out        o_valid / i_stall      index, inlier, sq_error, zero_depth, last
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  one point per cycle unless stalled; points pass projection, divider and error stages in turn
//  the 40-stage quotient pipeline sets the depth, one quotient bit per stage
//  a held result stalls the whole pipeline; nothing moves or drops while stalled
//  synchronous reset clears valid bits and the matrix and threshold registers
module point_reprojection_inlier_test_top #(
    parameter int INDEX_BITS = prit_pkg::INDEX_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [31:0]                 i_world_x,
    input  logic signed [31:0]                 i_world_y,
    input  logic signed [31:0]                 i_world_z,
    input  logic signed [31:0]                 i_image_u,
    input  logic signed [31:0]                 i_image_v,
    input  logic [prit_pkg::INDEX_PORT_BITS-1:0] i_point_index,
    input  logic                               i_last_point,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [prit_pkg::INDEX_PORT_BITS-1:0] o_index_out,
    output logic                               o_is_inlier,
    output logic [47:0]                        o_sq_error,
    output logic                               o_zero_depth,
    output logic                               o_last_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [prit_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [63:0]                        i_cfg_data
);

    localparam int IDX_KEEP = (INDEX_BITS < prit_pkg::INDEX_PORT_BITS) ?
                              INDEX_BITS : prit_pkg::INDEX_PORT_BITS;

    logic [5:0][63:0]      r_proj;
    logic [47:0]           r_limit;
    logic                  en;
    prit_pkg::t_side       r_side [0:prit_pkg::SIDE_DEPTH-1];
    logic [IDX_KEEP-1:0]   r_idx  [0:prit_pkg::SIDE_DEPTH-1];
    logic                  prj_valid;
    logic [2:0]            prj_neg;
    logic [2:0][63:0]      prj_mag;
    logic                  du_valid, dv_valid;
    logic [39:0]           quo_u, quo_v;
    logic                  ovf_u, ovf_v, neg_u, neg_v, zero_u, zero_v;
    logic [IDX_KEEP-1:0]   idx_out;

    assign o_cfg_ready = 1'b1;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proj  <= '0;
            r_limit <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == prit_pkg::CFG_LIMIT) begin
                r_limit <= i_cfg_data[47:0];
            end else if (i_cfg_index < prit_pkg::CFG_LIMIT) begin
                r_proj[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    // side data rides alongside projection and divider
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= '{image_u: i_image_u, image_v: i_image_v, last: i_last_point};
            r_idx[0]  <= i_point_index[IDX_KEEP-1:0];
            for (int k = 1; k < prit_pkg::SIDE_DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
                r_idx[k]  <= r_idx[k-1];
            end
        end
    end

    prit_project u_project (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_coef    (r_proj),
        .i_world_x (i_world_x),
        .i_world_y (i_world_y),
        .i_world_z (i_world_z),
        .o_valid   (prj_valid),
        .o_neg     (prj_neg),
        .o_mag     (prj_mag)
    );

    prit_divider u_div_u (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (prj_valid),
        .i_num      (prj_mag[0]),
        .i_den      (prj_mag[2]),
        .i_neg      (prj_neg[0] ^ prj_neg[2]),
        .o_valid    (du_valid),
        .o_quo      (quo_u),
        .o_ovf      (ovf_u),
        .o_neg      (neg_u),
        .o_den_zero (zero_u)
    );

    prit_divider u_div_v (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (prj_valid),
        .i_num      (prj_mag[1]),
        .i_den      (prj_mag[2]),
        .i_neg      (prj_neg[1] ^ prj_neg[2]),
        .o_valid    (dv_valid),
        .o_quo      (quo_v),
        .o_ovf      (ovf_v),
        .o_neg      (neg_v),
        .o_den_zero (zero_v)
    );

    prit_error #(
        .IDX_W (IDX_KEEP)
    ) u_error (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (du_valid & dv_valid),
        .i_quo_u    (quo_u),
        .i_ovf_u    (ovf_u),
        .i_neg_u    (neg_u),
        .i_quo_v    (quo_v),
        .i_ovf_v    (ovf_v),
        .i_neg_v    (neg_v),
        .i_zero     (zero_u | zero_v),
        .i_side     (r_side[prit_pkg::SIDE_DEPTH-1]),
        .i_index    (r_idx[prit_pkg::SIDE_DEPTH-1]),
        .i_limit    (r_limit),
        .o_valid    (o_valid),
        .o_index    (idx_out),
        .o_inlier   (o_is_inlier),
        .o_sq_error (o_sq_error),
        .o_zero     (o_zero_depth),
        .o_last     (o_last_out)
    );

    assign o_index_out = prit_pkg::INDEX_PORT_BITS'(idx_out);

endmodule

### tb/sv/prit_checker.sv
// checker for the reprojection inlier test: predicts each result and compares it
`timescale 1ns / 100ps
module prit_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_stall,
    input  logic signed [31:0]                   i_world_x,
    input  logic signed [31:0]                   i_world_y,
    input  logic signed [31:0]                   i_world_z,
    input  logic signed [31:0]                   i_image_u,
    input  logic signed [31:0]                   i_image_v,
    input  logic [prit_pkg::INDEX_PORT_BITS-1:0] i_point_index,
    input  logic                                 i_last_point,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  logic [prit_pkg::INDEX_PORT_BITS-1:0] o_index_out,
    input  logic                                 o_is_inlier,
    input  logic [47:0]                          o_sq_error,
    input  logic                                 o_zero_depth,
    input  logic                                 o_last_out,
    input  logic                                 i_cfg_valid,
    input  logic                                 o_cfg_ready,
    input  logic [prit_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [63:0]                          i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_seen
);

    typedef struct packed {
        logic [15:0] index;
        logic        inlier;
        logic [47:0] err;
        logic        zero;
        logic        last;
    } t_score;

    t_score      score_q[$];
    logic [63:0] proj_mat[prit_pkg::PROJ_REGS];
    logic [47:0] limit_sq;

    function automatic logic signed [31:0] coef_of(int row, int col);
        logic [63:0] r;
        r = proj_mat[row * 2 + col / 2];
        return (col % 2) ? r[63:32] : r[31:0];
    endfunction

    // exact row sum, fits comfortably in 128 bits
    function automatic logic signed [127:0] row_sum(int row, logic signed [31:0] x,
                                                    logic signed [31:0] y,
                                                    logic signed [31:0] z);
        logic signed [127:0] s;
        s = 128'(coef_of(row, 0)) * 128'(x) + 128'(coef_of(row, 1)) * 128'(y)
            + 128'(coef_of(row, 2)) * 128'(z) + 128'(coef_of(row, 3)) * 128'sd65536;
        return s;
    endfunction

    function automatic t_score score_point(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z, logic signed [31:0] u,
                                           logic signed [31:0] v, logic [15:0] idx,
                                           logic lst);
        t_score              s;
        logic signed [127:0] p0, p1, p2, qu, qv, du, dv;
        logic [127:0]        m0, m1, m2, mu, mv, au, av, tot;
        p0 = row_sum(0, x, y, z);
        p1 = row_sum(1, x, y, z);
        p2 = row_sum(2, x, y, z);
        s.index  = idx;
        s.last   = lst;
        s.zero   = 1'b0;
        s.inlier = 1'b0;
        s.err    = prit_pkg::ERR_MAX;
        if (p2 == 0) begin
            s.zero = 1'b1;
            return s;
        end
        m0 = p0 < 0 ? -p0 : p0;
        m1 = p1 < 0 ? -p1 : p1;
        m2 = p2 < 0 ? -p2 : p2;
        mu = (m0 << 16) / m2;
        mv = (m1 << 16) / m2;
        if (mu < (128'd1 << 40) && mv < (128'd1 << 40)) begin
            qu = ((p0 < 0) != (p2 < 0)) ? -$signed(mu) : $signed(mu);
            qv = ((p1 < 0) != (p2 < 0)) ? -$signed(mv) : $signed(mv);
            du = qu - 128'(u);
            dv = qv - 128'(v);
            au = du < 0 ? -du : du;
            av = dv < 0 ? -dv : dv;
            if (au < (128'd1 << 32) && av < (128'd1 << 32)) begin
                tot = (au * au + av * av) >> 16;
                s.err = (tot > 128'(prit_pkg::ERR_MAX)) ? prit_pkg::ERR_MAX : tot[47:0];
            end
        end
        s.inlier = s.err < limit_sq;
        return s;
    endfunction

    assign o_pending = score_q.size();

    always @(posedge i_clk) begin
        t_score want;
        t_score got;
        if (!i_rst_n) begin
            foreach (proj_mat[k]) proj_mat[k] <= '0;
            limit_sq     <= '0;
            o_fail_count <= 0;
            o_seen       <= 0;
            score_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index < prit_pkg::PROJ_REGS) proj_mat[i_cfg_index] <= i_cfg_data;
                else if (i_cfg_index == prit_pkg::CFG_LIMIT) limit_sq <= i_cfg_data[47:0];
            end
            if (i_valid && !o_stall)
                score_q = {score_q, score_point(i_world_x, i_world_y, i_world_z, i_image_u,
                                                i_image_v, i_point_index, i_last_point)};
            if (o_valid && !i_stall) begin
                o_seen <= o_seen + 1;
                got = '{o_index_out, o_is_inlier, o_sq_error, o_zero_depth, o_last_out};
                if (score_q.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = score_q.pop_front();
                    if (want !== got) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p actual %p", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/sv/tb_point_reprojection_inlier_test_top.sv
// stimulus and verdict for the reprojection inlier test
`timescale 1ns / 100ps
module tb_point_reprojection_inlier_test_top;

    logic               i_clk, i_rst_n;
    logic               i_valid, o_stall, o_valid, i_stall;
    logic signed [31:0] i_world_x, i_world_y, i_world_z, i_image_u, i_image_v;
    logic [15:0]        i_point_index, o_index_out;
    logic               i_last_point, o_is_inlier, o_zero_depth, o_last_out;
    logic [47:0]        o_sq_error;
    logic               i_cfg_valid, o_cfg_ready;
    logic [prit_pkg::CFG_IDX_BITS-1:0] i_cfg_index;
    logic [63:0]        i_cfg_data;
    int                 fail_count, pending, seen;
    int                 send_idle_pct, recv_stall_pct;
    int                 cycles;
    logic [15:0]        pt_count;

    point_reprojection_inlier_test_top i_dut (.*);

    prit_checker u_checker (.*, .o_fail_count(fail_count), .o_pending(pending),
                            .o_seen(seen));

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    always @(posedge i_clk) i_stall <= ($urandom_range(99) < recv_stall_pct);

    task automatic cfg_write(logic [prit_pkg::CFG_IDX_BITS-1:0] idx, logic [63:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] u, logic [31:0] v, logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        {i_world_x, i_world_y, i_world_z, i_image_u, i_image_v} <= {x, y, z, u, v};
        i_point_index <= pt_count;
        i_last_point  <= lst;
        pt_count++;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            default: return 32'($signed($urandom_range(400000)) - 200000) <<< 8;
        endcase
    endfunction

    function automatic logic [63:0] rand_pair();
        logic [31:0] a, b;
        a = $urandom_range(3) == 0 ? $urandom : 32'($signed($urandom_range(512)) - 256) <<< 12;
        b = $urandom_range(3) == 0 ? $urandom : 32'($signed($urandom_range(512)) - 256) <<< 12;
        if ($urandom_range(7) == 0) a = 0;
        return {b, a};
    endfunction

    // random, extreme or camera-like matrix; camera mode: focal terms on the diagonal, depth row near identity
    task automatic load_camera(int mode);
        int k;
        if (mode == 0) begin
            for (k = 0; k < prit_pkg::PROJ_REGS; k++)
                cfg_write(prit_pkg::CFG_IDX_BITS'(k), rand_pair());
        end else if (mode == 1) begin
            for (k = 0; k < prit_pkg::PROJ_REGS; k++)
                cfg_write(prit_pkg::CFG_IDX_BITS'(k),
                          $urandom_range(1) ? 64'h7FFFFFFF_7FFFFFFF : 64'h80000000_80000000);
        end else begin
            cfg_write(prit_pkg::CFG_ROW0_01, {32'h0, 32'd500 << 16});
            cfg_write(prit_pkg::CFG_ROW0_23, {32'd320 << 16, 32'($urandom_range(640)) << 16});
            cfg_write(prit_pkg::CFG_ROW1_01, {32'd500 << 16, 32'h0});
            cfg_write(prit_pkg::CFG_ROW1_23, {32'd240 << 16, 32'($urandom_range(480)) << 16});
            cfg_write(prit_pkg::CFG_ROW2_01, {32'($urandom_range(255)), 32'h0});
            cfg_write(prit_pkg::CFG_ROW2_23, {32'($urandom_range(3)) << 16, 32'h0001_0000});
        end
        cfg_write(prit_pkg::CFG_LIMIT, $urandom_range(1) ? {32'h0, 32'($urandom)}
                                                         : {16'h0, 16'($urandom), 32'($urandom)});
        cfg_write(prit_pkg::CFG_SPARE, {32'($urandom), 32'($urandom)});
    endtask

    initial begin
        int ph, n;
        logic [31:0] x, y, z, u, v;
        i_rst_n = 0; i_valid = 0; i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        {i_world_x, i_world_y, i_world_z, i_image_u, i_image_v} = '0;
        i_point_index = '0; i_last_point = 0;
        send_idle_pct = 0; recv_stall_pct = 0; pt_count = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // all-zero matrix: every point has zero depth
        send_point(32'h7FFFFFFF, 32'h80000000, 0, 32'hFFFFFFFF, 1, 1'b1);
        drain();
        cfg_write(prit_pkg::CFG_ROW0_01, 64'h0000_0000_0001_0000);
        cfg_write(prit_pkg::CFG_ROW0_23, 64'h0);
        cfg_write(prit_pkg::CFG_ROW1_01, 64'h0000_0001_0000_0000);
        cfg_write(prit_pkg::CFG_ROW1_23, 64'h0);
        cfg_write(prit_pkg::CFG_ROW2_01, 64'h0);
        cfg_write(prit_pkg::CFG_ROW2_23, 64'h0000_0000_0001_0000);
        cfg_write(prit_pkg::CFG_LIMIT, 64'h0000_0000_0001_0000);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
                   1'b0);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 0, 0, 1'b0);
        send_point(32'h7FFFFFFF, 32'h80000000, 32'h0000_0001, 0, 0, 1'b0);
        send_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                   1'b0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0);
        send_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0);
        send_point(0, 0, 0, 0, 0, 1'b0);
        send_point(32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 32'h0000_4000, 32'hFFFF_C000,
                   1'b1);
        drain();
        cfg_write(prit_pkg::CFG_LIMIT, 64'h0000_FFFF_FFFF_FFFF);
        send_point(32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_8000, 32'h0000_8000,
                   1'b0);
        send_point(32'h0001_0000, 0, 0, 0, 0, 1'b1);
        send_point(32'hFFFFFFFF, 32'h0000_0001, 32'h0000_0003, 32'h1234_5678, 32'hEDCB_A987,
                   1'b1);
        drain();
        for (ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            load_camera(ph % 3 == 1 && ph != 1 ? 1 : (ph % 3 == 0 ? 2 : 0));
            for (n = 0; n < 120; n++) begin
                x = rand_coord(); y = rand_coord(); z = rand_coord();
                u = rand_coord(); v = rand_coord();
                if ($urandom_range(15) == 0) {x, y, z} = '0;
                send_point(x, y, z, u, v, 1'($urandom_range(1)));
            end
            drain();
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        $display("covered %0d points over 12 matrix and threshold settings", seen);
        $display("with zero-depth, saturation and stall/idle phases on both channels");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
